// ===== rtl/av1d_pkg.sv =====
// Shared types, codes and helpers for the AV1 RTP payload depacketizer.
package av1d_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_DATA   = 3'd2,
        PH_REST   = 3'd3,
        PH_DRAIN  = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ST_Z_AND_N     = 3'd2;
    localparam logic [2:0] ST_LEN_OVF     = 3'd3;
    localparam logic [2:0] ST_LEN_TRUNC   = 3'd4;
    localparam logic [2:0] ST_ELEM_TRUNC  = 3'd5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // flags layout: [4] Z, [3] Y, [2:1] W, [0] N
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] element_byte;
        logic [7:0] element_index;
        logic       element_end;
        logic [2:0] status_code;
        logic       z_flag;
        logic       y_flag;
        logic       n_flag;
        logic [1:0] w_count;
    } t_result;

    typedef struct packed {
        logic    vld0;
        logic    vld1;
        t_result res0;
        t_result res1;
    } t_push;

    function automatic t_result mk_result(
        input logic [1:0] kind,
        input logic [7:0] data,
        input logic [7:0] index,
        input logic       last,
        input logic [2:0] status,
        input logic [4:0] flags
    );
        t_result r;
        r.kind          = kind;
        r.element_byte  = data;
        r.element_index = index;
        r.element_end   = last;
        r.status_code   = status;
        r.z_flag        = flags[4];
        r.y_flag        = flags[3];
        r.n_flag        = flags[0];
        r.w_count       = flags[2:1];
        return r;
    endfunction

endpackage

// ===== rtl/av1d_parse.sv =====
// Per-byte parser: aggregation header, LEB128 lengths and element framing.
module av1d_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output av1d_pkg::t_push  o_push
);

    av1d_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_accum, n_accum;
    logic [2:0]  r_shift, n_shift;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_count, n_count;
    logic [4:0]  r_flags, n_flags;
    logic [2:0]  r_err, n_err;

    logic        is_hdr;
    logic [4:0]  cur_flags;
    logic [7:0]  beg_count;
    logic [1:0]  el_w;
    logic        beg_rest;
    logic [31:0] len_bits;
    logic [31:0] acc_new;
    logic [31:0] left_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= av1d_pkg::PH_HEADER;
            r_accum <= '0;
            r_shift <= '0;
            r_left  <= '0;
            r_count <= '0;
            r_flags <= '0;
            r_err   <= '0;
        end else begin
            r_phase <= n_phase;
            r_accum <= n_accum;
            r_shift <= n_shift;
            r_left  <= n_left;
            r_count <= n_count;
            r_flags <= n_flags;
            r_err   <= n_err;
        end
    end

    always_comb begin
        is_hdr = !(r_phase == av1d_pkg::PH_LEN || r_phase == av1d_pkg::PH_DATA ||
                   r_phase == av1d_pkg::PH_REST || r_phase == av1d_pkg::PH_DRAIN);
        cur_flags = is_hdr ? i_byte[7:3] : r_flags;
        el_w      = is_hdr ? i_byte[5:4] : r_flags[2:1];
        beg_count = (is_hdr ? 8'd0 : r_count) + 8'd1;
        beg_rest  = (el_w != 2'd0) && (beg_count == {6'd0, el_w});

        case (r_shift[1:0])
            2'd0: len_bits = {25'd0, i_byte[6:0]};
            2'd1: len_bits = {18'd0, i_byte[6:0], 7'd0};
            2'd2: len_bits = {11'd0, i_byte[6:0], 14'd0};
            2'd3: len_bits = {4'd0, i_byte[6:0], 21'd0};
            default: len_bits = '0;
        endcase
        acc_new  = r_shift[2] ? (r_accum | {i_byte[3:0], 28'd0}) : (r_accum | len_bits);
        left_dec = r_left - 32'd1;

        n_phase = r_phase;
        n_accum = r_accum;
        n_shift = r_shift;
        n_left  = r_left;
        n_count = r_count;
        n_flags = r_flags;
        n_err   = r_err;
        o_push.vld0 = 1'b0;
        o_push.vld1 = 1'b0;
        o_push.res0 = av1d_pkg::mk_result(av1d_pkg::KIND_STATUS, 8'd0, 8'd0, 1'b0,
                                          av1d_pkg::ST_OK, cur_flags);
        o_push.res1 = o_push.res0;

        if (i_vld) begin
            unique case (r_phase)
                av1d_pkg::PH_LEN: begin
                    if (r_shift[2] && i_byte[7:4] != 4'd0) begin
                        n_err   = av1d_pkg::ST_LEN_OVF;
                        n_phase = av1d_pkg::PH_DRAIN;
                        if (i_last) begin
                            o_push.vld0 = 1'b1;
                            o_push.res0.status_code = av1d_pkg::ST_LEN_OVF;
                        end
                    end else if (!r_shift[2] && i_byte[7]) begin
                        n_accum = acc_new;
                        n_shift = r_shift + 3'd1;
                        if (i_last) begin
                            o_push.vld0 = 1'b1;
                            o_push.res0.status_code = av1d_pkg::ST_LEN_TRUNC;
                        end
                    end else if (acc_new == 32'd0) begin
                        o_push.vld0 = 1'b1;
                        o_push.res0 = av1d_pkg::mk_result(av1d_pkg::KIND_EMPTY, 8'd0,
                                          r_count, 1'b1, av1d_pkg::ST_OK, cur_flags);
                        if (i_last) begin
                            o_push.vld1 = 1'b1;
                        end else begin
                            n_count = beg_count;
                            n_accum = '0;
                            n_shift = '0;
                            n_left  = '0;
                            n_phase = beg_rest ? av1d_pkg::PH_REST : av1d_pkg::PH_LEN;
                        end
                    end else if (i_last) begin
                        o_push.vld0 = 1'b1;
                        o_push.res0.status_code = av1d_pkg::ST_ELEM_TRUNC;
                    end else begin
                        n_accum = acc_new;
                        n_left  = acc_new;
                        n_phase = av1d_pkg::PH_DATA;
                    end
                end
                av1d_pkg::PH_DATA: begin
                    o_push.vld0 = 1'b1;
                    o_push.res0 = av1d_pkg::mk_result(av1d_pkg::KIND_DATA, i_byte, r_count,
                                      left_dec == 32'd0, av1d_pkg::ST_OK, cur_flags);
                    if (left_dec == 32'd0) begin
                        if (i_last) begin
                            o_push.vld1 = 1'b1;
                        end else begin
                            n_count = beg_count;
                            n_accum = '0;
                            n_shift = '0;
                            n_left  = '0;
                            n_phase = beg_rest ? av1d_pkg::PH_REST : av1d_pkg::PH_LEN;
                        end
                    end else begin
                        n_left = left_dec;
                        if (i_last) begin
                            o_push.vld1 = 1'b1;
                            o_push.res1.status_code = av1d_pkg::ST_ELEM_TRUNC;
                        end
                    end
                end
                av1d_pkg::PH_REST: begin
                    o_push.vld0 = 1'b1;
                    o_push.res0 = av1d_pkg::mk_result(av1d_pkg::KIND_DATA, i_byte, r_count,
                                      i_last, av1d_pkg::ST_OK, cur_flags);
                    o_push.vld1 = i_last;
                end
                av1d_pkg::PH_DRAIN: begin
                    if (i_last) begin
                        o_push.vld0 = 1'b1;
                        o_push.res0.status_code = r_err;
                    end
                end
                default: begin
                    n_accum = '0;
                    n_shift = '0;
                    n_left  = '0;
                    n_count = '0;
                    n_err   = '0;
                    n_flags = i_byte[7:3];
                    if (i_last) begin
                        o_push.vld0 = 1'b1;
                        o_push.res0.status_code = av1d_pkg::ST_TOO_SHORT;
                    end else if (i_byte[7] && i_byte[3]) begin
                        n_err   = av1d_pkg::ST_Z_AND_N;
                        n_phase = av1d_pkg::PH_DRAIN;
                    end else begin
                        n_count = beg_count;
                        n_phase = beg_rest ? av1d_pkg::PH_REST : av1d_pkg::PH_LEN;
                    end
                end
            endcase

            if (i_last) begin
                n_phase = av1d_pkg::PH_HEADER;
                n_accum = '0;
                n_shift = '0;
                n_left  = '0;
                n_count = '0;
                n_flags = '0;
                n_err   = '0;
            end
        end
    end

endmodule

// ===== rtl/av1d_fifo.sv =====
// Output word queue taking up to two words per cycle and giving one.
module av1d_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  av1d_pkg::t_push   i_push,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output av1d_pkg::t_result o_data
);

    av1d_pkg::t_result r_mem [av1d_pkg::FIFO_DEPTH];
    logic [av1d_pkg::FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [av1d_pkg::FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [av1d_pkg::FIFO_CW-1:0] r_cnt, n_cnt;
    logic [av1d_pkg::FIFO_CW-1:0] push_n;
    logic pop;

    always_comb begin
        pop      = (r_cnt != '0) && i_ready;
        push_n   = {{(av1d_pkg::FIFO_CW-1){1'b0}}, i_push.vld0} +
                   {{(av1d_pkg::FIFO_CW-1){1'b0}}, i_push.vld1};
        n_wr_ptr = r_wr_ptr + push_n[av1d_pkg::FIFO_AW-1:0];
        n_rd_ptr = r_rd_ptr + {{(av1d_pkg::FIFO_AW-1){1'b0}}, pop};
        n_cnt    = r_cnt + push_n - {{(av1d_pkg::FIFO_CW-1){1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.vld1) begin
            r_mem[r_wr_ptr + {{(av1d_pkg::FIFO_AW-1){1'b0}}, 1'b1}] <= i_push.res1;
        end
    end

    assign o_space = (r_cnt <= av1d_pkg::FIFO_CW'(av1d_pkg::FIFO_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/av1_rtp_payload_depacketizer.sv =====
// Top level of the AV1 RTP payload depacketizer.
// Input channel: one RTP payload byte per word (i_data_byte, i_last_byte),
// handshake i_valid / o_ready. The first byte of each payload is the
// aggregation header; i_last_byte marks the payload's final byte.
// Output channel: one word per element byte, empty element or packet
// status (o_kind and the fields beside it), handshake o_valid / i_ready.
// A payload's final byte gives up to two words: its element word and then
// the status word. On a nonzero status, downstream must drop the packet's
// words; the block itself does not enforce this. An accepted byte waits in
// the input register until the queue has space and is then parsed.
// Throughput: one byte per cycle while the queue has space, set by the
// single parse stage between the input register and the 4-word output
// queue; the two words of a final byte drain at one per cycle while i_ready
// is high; input keeps flowing while the queue holds two or fewer words.
// When i_ready is low the queue fills, the parse stage holds its byte and
// o_ready drops; nothing is lost.
// Reset (synchronous, active low) empties the queue and input register and
// returns the parser to waiting for a header byte.
module av1_rtp_payload_depacketizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_element_byte,
    output logic [7:0] o_element_index,
    output logic       o_element_end,
    output logic [2:0] o_status_code,
    output logic       o_z_flag,
    output logic       o_y_flag,
    output logic       o_n_flag,
    output logic [1:0] o_w_count
);

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       space;
    logic       consume;
    av1d_pkg::t_push   push;
    av1d_pkg::t_result res;

    assign consume = r_in_vld && space;
    assign o_ready = !r_in_vld || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    av1d_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (consume),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_push  (push)
    );

    av1d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res)
    );

    assign o_kind          = res.kind;
    assign o_element_byte  = res.element_byte;
    assign o_element_index = res.element_index;
    assign o_element_end   = res.element_end;
    assign o_status_code   = res.status_code;
    assign o_z_flag        = res.z_flag;
    assign o_y_flag        = res.y_flag;
    assign o_n_flag        = res.n_flag;
    assign o_w_count       = res.w_count;

endmodule
